>>> rtl/skbc_pkg.sv
// Types, constants and round functions for the SKINNY-128-384 cipher.
// Used by every module of the block; no dependencies.
package skbc_pkg;

	localparam int unsigned ROUND_COUNT_DEF = 56;
	localparam int unsigned CFG_IDX_W = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TK1_LO = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TK1_HI = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TK2_LO = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TK2_HI = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TK3_LO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TK3_HI = 3'd5;

	// Constant row-2 round constant
	localparam logic [7:0] RC_ROW2 = 8'h02;
	localparam logic [5:0] RC_MASK = 6'h3F;

	// 16 byte cells, cell i at bits 8i (matches {high, low} word packing)
	typedef logic [15:0][7:0] blk_t;

	typedef struct packed {
		logic dec;
		blk_t st;
		blk_t t1;
		blk_t t2;
		blk_t t3;
	} pipe_t;

	// Tweakey cell permutation
	localparam logic [3:0] TK_PERM [16] = '{
		4'd9, 4'd15, 4'd8, 4'd13, 4'd10, 4'd14, 4'd12, 4'd11,
		4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7
	};

	// Round constant LFSR value used in round n (elaboration only)
	function automatic logic [5:0] rc_at(input int unsigned n);
		logic [5:0] rc;
		rc = '0;
		for (int unsigned k = 0; k <= n; k++) begin
			rc = {rc[4:0], 1'b0} ^ {5'd0, rc[5] ^ rc[4] ^ 1'b1};
			rc = rc & RC_MASK;
		end
		return rc;
	endfunction

	function automatic logic [7:0] nor_layer(input logic [7:0] x);
		logic [7:0] y;
		y = x;
		y[4] = y[4] ^ ~(y[7] | y[6]);
		y[0] = y[0] ^ ~(y[3] | y[2]);
		return y;
	endfunction

	function automatic logic [7:0] wire_layer(input logic [7:0] x);
		return {x[2], x[1], x[7], x[6], x[4], x[0], x[3], x[5]};
	endfunction

	function automatic logic [7:0] wire_layer_inv(input logic [7:0] y);
		logic [7:0] x;
		x[2] = y[7];
		x[1] = y[6];
		x[7] = y[5];
		x[6] = y[4];
		x[4] = y[3];
		x[0] = y[2];
		x[3] = y[1];
		x[5] = y[0];
		return x;
	endfunction

	function automatic logic [7:0] sbox_fwd(input logic [7:0] x);
		logic [7:0] y;
		y = x;
		for (int k = 0; k < 3; k++) y = wire_layer(nor_layer(y));
		y = nor_layer(y);
		return {y[7:3], y[1], y[2], y[0]};
	endfunction

	// nor_layer is its own inverse
	function automatic logic [7:0] sbox_inv(input logic [7:0] x);
		logic [7:0] y;
		y = {x[7:3], x[1], x[2], x[0]};
		y = nor_layer(y);
		for (int k = 0; k < 3; k++) y = nor_layer(wire_layer_inv(y));
		return y;
	endfunction

	function automatic logic [7:0] lfsr2(input logic [7:0] x);
		return {x[6:0], x[7] ^ x[5]};
	endfunction

	function automatic logic [7:0] lfsr2_inv(input logic [7:0] y);
		return {y[0] ^ y[6], y[7:1]};
	endfunction

	function automatic logic [7:0] lfsr3(input logic [7:0] x);
		return {x[0] ^ x[6], x[7:1]};
	endfunction

	function automatic logic [7:0] lfsr3_inv(input logic [7:0] y);
		return {y[6:0], y[7] ^ y[5]};
	endfunction

	// One step of the tweakey schedule: permute cells, LFSR top rows
	function automatic pipe_t tk_step(input pipe_t p);
		pipe_t q;
		q = p;
		for (int i = 0; i < 16; i++) begin
			q.t1[i] = p.t1[TK_PERM[i]];
			q.t2[i] = p.t2[TK_PERM[i]];
			q.t3[i] = p.t3[TK_PERM[i]];
		end
		for (int i = 0; i < 8; i++) begin
			q.t2[i] = lfsr2(q.t2[i]);
			q.t3[i] = lfsr3(q.t3[i]);
		end
		return q;
	endfunction

	// Inverse step: undo the LFSRs, then the permutation
	function automatic pipe_t tk_step_inv(input pipe_t p);
		pipe_t q;
		blk_t a2;
		blk_t a3;
		q = p;
		a2 = p.t2;
		a3 = p.t3;
		for (int i = 0; i < 8; i++) begin
			a2[i] = lfsr2_inv(p.t2[i]);
			a3[i] = lfsr3_inv(p.t3[i]);
		end
		for (int i = 0; i < 16; i++) begin
			q.t1[TK_PERM[i]] = p.t1[i];
			q.t2[TK_PERM[i]] = a2[i];
			q.t3[TK_PERM[i]] = a3[i];
		end
		return q;
	endfunction

	// Add round constants and round tweakey
	function automatic blk_t add_key(input blk_t s, input pipe_t k, input logic [5:0] rc);
		blk_t o;
		o = s;
		o[0] = o[0] ^ {4'd0, rc[3:0]};
		o[4] = o[4] ^ {6'd0, rc[5:4]};
		o[8] = o[8] ^ RC_ROW2;
		for (int i = 0; i < 8; i++) o[i] = o[i] ^ k.t1[i] ^ k.t2[i] ^ k.t3[i];
		return o;
	endfunction

	function automatic blk_t round_enc(input blk_t s_in, input pipe_t k, input logic [5:0] rc);
		blk_t s;
		blk_t o;
		blk_t r;
		logic [7:0] a, b, c, d;
		for (int i = 0; i < 16; i++) s[i] = sbox_fwd(s_in[i]);
		s = add_key(s, k, rc);
		for (int i = 0; i < 16; i++) o[(i & 12) | (((i & 3) + (i >> 2)) & 3)] = s[i];
		for (int i = 0; i < 4; i++) begin
			a = o[i];
			b = o[4+i] ^ o[8+i];
			c = o[8+i] ^ a;
			d = o[12+i] ^ c;
			r[i] = d;
			r[4+i] = a;
			r[8+i] = b;
			r[12+i] = c;
		end
		return r;
	endfunction

	function automatic blk_t round_dec(input blk_t s_in, input pipe_t k, input logic [5:0] rc);
		blk_t o;
		blk_t s;
		logic [7:0] r2;
		for (int i = 0; i < 4; i++) begin
			r2 = s_in[12+i] ^ s_in[4+i];
			o[i] = s_in[4+i];
			o[4+i] = s_in[8+i] ^ r2;
			o[8+i] = r2;
			o[12+i] = s_in[i] ^ s_in[12+i];
		end
		for (int i = 0; i < 16; i++) s[i] = o[(i & 12) | (((i & 3) + (i >> 2)) & 3)];
		s = add_key(s, k, rc);
		for (int i = 0; i < 16; i++) s[i] = sbox_inv(s[i]);
		return s;
	endfunction

endpackage

>>> rtl/skbc_tk_stage.sv
// Tweakey fast-forward pipeline stage: decrypt beats advance the schedule one round.
// Depends on skbc_pkg.
module skbc_tk_stage import skbc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  in_vld,
	input  pipe_t in_data,
	output logic  out_vld,
	output pipe_t out_data
);

	logic  vld_s1;
	pipe_t data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	// encrypt beats pass through untouched
	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= in_data.dec ? tk_step(in_data) : in_data;
		end
	end

	assign out_vld  = vld_s1;
	assign out_data = data_s1;

endmodule

>>> rtl/skbc_round_stage.sv
// One cipher round as a pipeline stage, encrypt or decrypt per beat.
// Depends on skbc_pkg.
module skbc_round_stage import skbc_pkg::*; #(
	parameter logic [5:0] RC_ENC = 6'd1,
	parameter logic [5:0] RC_DEC = 6'd1
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  in_vld,
	input  pipe_t in_data,
	output logic  out_vld,
	output pipe_t out_data
);

	logic  vld_s1;
	pipe_t data_s1;
	pipe_t fwd;
	pipe_t bwd;
	pipe_t nxt;

	// encrypt uses the key then steps it; decrypt steps back then uses it
	always_comb begin
		fwd = tk_step(in_data);
		bwd = tk_step_inv(in_data);
		if (in_data.dec) begin
			nxt = bwd;
			nxt.st = round_dec(in_data.st, bwd, RC_DEC);
		end else begin
			nxt = fwd;
			nxt.st = round_enc(in_data.st, in_data, RC_ENC);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= nxt;
		end
	end

	assign out_vld  = vld_s1;
	assign out_data = data_s1;

endmodule

>>> rtl/skinny128_384_block_cipher.sv
// SKINNY-128-384 tweakable block cipher, fully unrolled pipeline.
// Depends on skbc_pkg, skbc_tk_stage, skbc_round_stage.
//
// Usage:
//   Input beat (in_valid/in_stall): mode, block, per-item TK2. Mode bit 0
//   selects decryption, bit 1 selects the per-item TK2 over the TK2 registers.
//   Output beat (out_valid/out_stall): the processed block.
//   TK1/TK2/TK3 are written through cfg_we/cfg_index/cfg_data while idle.
// Pipeline: the first ROUND_COUNT stages fast-forward the tweakey schedule for
//   decrypt beats, the next ROUND_COUNT stages each compute one round.
// Throughput: one block per cycle while no result is stalled; every stage is
//   a register of the pipeline and beats of any mode may follow each other
//   back to back.
// Reset clears all stage valid bits and the tweakey registers to zero.
// When the receiver stalls a waiting result, the whole pipeline holds and
//   in_stall is raised; holes in the pipeline still fill while the output
//   stage is empty.
module skinny128_384_block_cipher import skbc_pkg::*; #(
	parameter int unsigned ROUND_COUNT = ROUND_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           mode,
	input  logic [63:0]          block_low,
	input  logic [63:0]          block_high,
	input  logic [63:0]          item_tweak_two_low,
	input  logic [63:0]          item_tweak_two_high,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [63:0]          result_low,
	output logic [63:0]          result_high,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	localparam int unsigned NSTG = 2 * ROUND_COUNT;

	logic [63:0] tk1_lo_q, tk1_hi_q, tk2_lo_q, tk2_hi_q, tk3_lo_q, tk3_hi_q;
	logic        vld [NSTG+1];
	pipe_t       dat [NSTG+1];
	logic        adv;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tk1_lo_q <= '0;
			tk1_hi_q <= '0;
			tk2_lo_q <= '0;
			tk2_hi_q <= '0;
			tk3_lo_q <= '0;
			tk3_hi_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TK1_LO: tk1_lo_q <= cfg_data;
				REG_TK1_HI: tk1_hi_q <= cfg_data;
				REG_TK2_LO: tk2_lo_q <= cfg_data;
				REG_TK2_HI: tk2_hi_q <= cfg_data;
				REG_TK3_LO: tk3_lo_q <= cfg_data;
				REG_TK3_HI: tk3_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Global advance: hold everything only while a result waits
	assign adv      = !vld[NSTG] || !out_stall;
	assign in_stall = !adv;

	// Stage input
	always_comb begin
		vld[0]     = in_valid;
		dat[0].dec = mode[0];
		dat[0].st  = {block_high, block_low};
		dat[0].t1  = {tk1_hi_q, tk1_lo_q};
		dat[0].t2  = mode[1] ? {item_tweak_two_high, item_tweak_two_low}
		                     : {tk2_hi_q, tk2_lo_q};
		dat[0].t3  = {tk3_hi_q, tk3_lo_q};
	end

	// Tweakey fast-forward stages
	for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_tk
		skbc_tk_stage u_tk (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_vld   (vld[g]),
			.in_data  (dat[g]),
			.out_vld  (vld[g+1]),
			.out_data (dat[g+1])
		);
	end

	// Round stages
	for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_rnd
		skbc_round_stage #(
			.RC_ENC (rc_at(g)),
			.RC_DEC (rc_at(ROUND_COUNT - 1 - g))
		) u_rnd (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_vld   (vld[ROUND_COUNT+g]),
			.in_data  (dat[ROUND_COUNT+g]),
			.out_vld  (vld[ROUND_COUNT+g+1]),
			.out_data (dat[ROUND_COUNT+g+1])
		);
	end

	assign out_valid   = vld[NSTG];
	assign result_low  = dat[NSTG].st[7:0];
	assign result_high = dat[NSTG].st[15:8];

endmodule

>>> bench/testbench.sv
// Self-checking bench for the SKINNY-128-384 pipelined cipher block.
// Depends on skbc_pkg and skinny128_384_block_cipher; predicts every block
// with its own model of the rounds and compares each output beat.
`timescale 1ns / 100ps

module testbench;
	import skbc_pkg::*;

	localparam int NROUNDS = 56;

	typedef struct {
		logic [1:0]  mode;
		logic [63:0] blk_lo;
		logic [63:0] blk_hi;
		logic [63:0] tk2_lo;
		logic [63:0] tk2_hi;
	} cipher_job_t;

	typedef struct {
		logic [63:0] lo;
		logic [63:0] hi;
	} cipher_block_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] mode = '0;
	logic [63:0] block_low = '0;
	logic [63:0] block_high = '0;
	logic [63:0] item_tweak_two_low = '0;
	logic [63:0] item_tweak_two_high = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [63:0] result_low;
	logic [63:0] result_high;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	// Mirror of the tweakey registers
	logic [63:0] tk_mirror [6];

	cipher_job_t   pending_jobs [$];
	cipher_block_t expected_blocks [$];
	int unsigned   fail_count = 0;
	logic [7:0]    sbox_inverse [256];

	skinny128_384_block_cipher dut (.*);

	always #6 clk = ~clk;

	// S-box built from its NOR/wiring layers
	function automatic logic [7:0] nor_mix(input logic [7:0] x);
		x[4] = x[4] ^ ~(x[7] | x[6]);
		x[0] = x[0] ^ ~(x[3] | x[2]);
		return x;
	endfunction

	function automatic logic [7:0] sbox_forward(input logic [7:0] x);
		for (int k = 0; k < 3; k++) begin
			x = nor_mix(x);
			x = {x[2], x[1], x[7], x[6], x[4], x[0], x[3], x[5]};
		end
		x = nor_mix(x);
		return {x[7:3], x[1], x[2], x[0]};
	endfunction

	function automatic int shift_pos(input int i);
		return (i & 12) | (((i & 3) + (i >> 2)) & 3);
	endfunction

	// Full cipher for one job under the current tweakey mirror
	function automatic cipher_block_t skinny_predict(input cipher_job_t j);
		logic [7:0] s [16];
		logic [7:0] o [16];
		logic [7:0] t1 [16];
		logic [7:0] t2 [16];
		logic [7:0] t3 [16];
		logic [7:0] p1 [16];
		logic [7:0] p2 [16];
		logic [7:0] p3 [16];
		logic [7:0] rkey [NROUNDS][8];
		logic [5:0] rcon [NROUNDS];
		logic [5:0] rc;
		logic [7:0] a, b, c, d, x;
		logic [63:0] w2lo, w2hi;
		cipher_block_t res;
		int r;
		w2lo = j.mode[1] ? j.tk2_lo : tk_mirror[2];
		w2hi = j.mode[1] ? j.tk2_hi : tk_mirror[3];
		for (int i = 0; i < 8; i++) begin
			s[i] = j.blk_lo[8*i +: 8];      s[i+8] = j.blk_hi[8*i +: 8];
			t1[i] = tk_mirror[0][8*i +: 8]; t1[i+8] = tk_mirror[1][8*i +: 8];
			t2[i] = w2lo[8*i +: 8];         t2[i+8] = w2hi[8*i +: 8];
			t3[i] = tk_mirror[4][8*i +: 8]; t3[i+8] = tk_mirror[5][8*i +: 8];
		end
		// tweakey schedule and round constants
		rc = '0;
		for (int n = 0; n < NROUNDS; n++) begin
			rc = {rc[4:0], 1'b0} ^ {5'd0, rc[5] ^ rc[4] ^ 1'b1};
			rcon[n] = rc;
			for (int i = 0; i < 8; i++) rkey[n][i] = t1[i] ^ t2[i] ^ t3[i];
			p1 = t1; p2 = t2; p3 = t3;
			for (int i = 0; i < 16; i++) begin
				t1[i] = p1[TK_PERM[i]];
				t2[i] = p2[TK_PERM[i]];
				t3[i] = p3[TK_PERM[i]];
			end
			for (int i = 0; i < 8; i++) begin
				x = t2[i]; t2[i] = {x[6:0], x[7] ^ x[5]};
				x = t3[i]; t3[i] = {x[0] ^ x[6], x[7:1]};
			end
		end
		for (int n = 0; n < NROUNDS; n++) begin
			r = j.mode[0] ? NROUNDS - 1 - n : n;
			if (!j.mode[0]) begin
				for (int i = 0; i < 16; i++) s[i] = sbox_forward(s[i]);
			end else begin
				// inverse MixColumns, inverse ShiftRows
				for (int i = 0; i < 4; i++) begin
					a = s[i]; b = s[4+i]; c = s[8+i]; d = s[12+i];
					o[i] = b;
					o[4+i] = c ^ d ^ b;
					o[8+i] = d ^ b;
					o[12+i] = a ^ d;
				end
				for (int i = 0; i < 16; i++) s[i] = o[shift_pos(i)];
			end
			s[0] = s[0] ^ {4'd0, rcon[r][3:0]};
			s[4] = s[4] ^ {6'd0, rcon[r][5:4]};
			s[8] = s[8] ^ 8'h02;
			for (int i = 0; i < 8; i++) s[i] = s[i] ^ rkey[r][i];
			if (!j.mode[0]) begin
				for (int i = 0; i < 16; i++) o[shift_pos(i)] = s[i];
				for (int i = 0; i < 4; i++) begin
					a = o[i]; b = o[4+i] ^ o[8+i]; c = o[8+i] ^ o[i]; d = o[12+i] ^ c;
					s[i] = d; s[4+i] = a; s[8+i] = b; s[12+i] = c;
				end
			end else begin
				for (int i = 0; i < 16; i++) s[i] = sbox_inverse[s[i]];
			end
		end
		for (int i = 0; i < 8; i++) begin
			res.lo[8*i +: 8] = s[i];
			res.hi[8*i +: 8] = s[i+8];
		end
		return res;
	endfunction

	// Driver: bursts of beats with random gaps
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		cipher_job_t job;
		logic taken;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			taken = in_valid && !in_stall;
			if (taken) begin
				job.mode = mode; job.blk_lo = block_low; job.blk_hi = block_high;
				job.tk2_lo = item_tweak_two_low; job.tk2_hi = item_tweak_two_high;
				expected_blocks.push_back(skinny_predict(job));
			end
			if (!in_valid || taken) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_jobs.size() > 0) begin
					job = pending_jobs.pop_front();
					mode <= job.mode;
					block_low <= job.blk_lo;
					block_high <= job.blk_hi;
					item_tweak_two_low <= job.tk2_lo;
					item_tweak_two_high <= job.tk2_hi;
					in_valid <= 1'b1;
					if (burst_left > 0) burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall pattern changes periodically
	int unsigned stall_cycle = 0;
	int unsigned stall_pct = 0;
	always @(posedge clk) begin
		cipher_block_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_blocks.size() == 0) begin
				$error("output beat with no block expected");
				fail_count++;
			end else begin
				want = expected_blocks.pop_front();
				if (result_low !== want.lo) begin
					$error("result_low expected %h actual %h", want.lo, result_low);
					fail_count++;
				end
				if (result_high !== want.hi) begin
					$error("result_high expected %h actual %h", want.hi, result_high);
					fail_count++;
				end
			end
		end
		stall_cycle++;
		if (stall_cycle % 300 == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
		end
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	function automatic logic [63:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx < 6) tk_mirror[idx] = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_jobs.size() > 0 || in_valid || expected_blocks.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_job(input logic [1:0] m, input logic [63:0] bl, input logic [63:0] bh,
			input logic [63:0] tl, input logic [63:0] th);
		cipher_job_t j;
		j.mode = m; j.blk_lo = bl; j.blk_hi = bh; j.tk2_lo = tl; j.tk2_hi = th;
		pending_jobs.push_back(j);
	endtask

	task automatic queue_random(input int n);
		repeat (n)
			queue_job(2'($urandom_range(0, 3)), pick_word(), pick_word(), pick_word(),
				pick_word());
	endtask

	// Inverse S-box table
	initial begin
		for (int v = 0; v < 256; v++) sbox_inverse[sbox_forward(v[7:0])] = v[7:0];
	end

	// Stimulus
	initial begin
		for (int i = 0; i < 6; i++) tk_mirror[i] = '0;
		#1;
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero tweakey after reset, every mode, field extremes
		for (int m = 0; m < 4; m++) begin
			queue_job(m[1:0], '0, '0, '0, '0);
			queue_job(m[1:0], '1, '1, '1, '1);
			queue_job(m[1:0], 64'h0706050403020100, 64'h0f0e0d0c0b0a0908, '1, '0);
		end
		// per-item TK2 must be ignored in modes 0 and 1
		queue_job(2'd0, 64'h1234, '0, 64'hdeadbeef, '1);
		queue_job(2'd1, 64'h1234, '0, 64'hdeadbeef, '1);
		wait_idle();

		// all-ones tweakey
		for (int i = 0; i < 6; i++) write_reg(i[CFG_IDX_W-1:0], '1);
		for (int m = 0; m < 4; m++) begin
			queue_job(m[1:0], '0, '1, '0, '1);
			queue_job(m[1:0], '1, '0, '1, '0);
		end
		queue_random(40);
		wait_idle();

		// writes to unused indexes change nothing
		write_reg(3'd6, 64'h5555aaaa5555aaaa);
		write_reg(3'd7, '0);
		queue_random(40);
		wait_idle();

		// random tweakeys across several phases, one with zeros
		for (int ph = 0; ph < 7; ph++) begin
			for (int i = 0; i < 6; i++)
				write_reg(i[CFG_IDX_W-1:0], (ph == 3) ? 64'd0 : pick_word());
			queue_random(210);
			wait_idle();
		end

		repeat (130) @(posedge clk);
		if (fail_count == 0 && expected_blocks.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> files.f
rtl/skbc_pkg.sv
rtl/skbc_tk_stage.sv
rtl/skbc_round_stage.sv
rtl/skinny128_384_block_cipher.sv
bench/testbench.sv
